// ===== design/fto_pkg.sv =====
// fto_pkg: shared types and constants for the FM tone oscillator.
// Used by fto_ctrl, fto_sine_rom, fto_datapath and fm_tone_oscillator_core.
package fto_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_WIDTH_DEF      = 32;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int GAIN_W      = 17;   // Q16 gain registers, 65536 is one
  localparam int SINE_W      = 17;   // signed sine, -32768..32768

  localparam logic [CFG_DATA_W-1:0] CARRIER_INC_RST   = 32'd42852281;
  localparam logic [CFG_DATA_W-1:0] MODULATOR_INC_RST = 32'd19478309;
  localparam logic [GAIN_W-1:0]     STRENGTH_RST      = 17'd65536;
  localparam logic [GAIN_W-1:0]     VOLUME_RST        = 17'd6554;
  localparam logic [GAIN_W-1:0]     ONE_Q16           = 17'd65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CARRIER_INC   = 2'd0,
    CFG_MODULATOR_INC = 2'd1,
    CFG_STRENGTH      = 2'd2,
    CFG_VOLUME        = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  // operand pairing for the shared multiplier
  typedef enum logic [1:0] {
    MUL_DEPTH = 2'd0,   // strength * modulation depth
    MUL_STEP  = 2'd1,   // carrier increment * step factor
    MUL_TONE  = 2'd2    // carrier sine * volume
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mod_adv;
    logic     rom_rd;
    logic     rom_sel_car;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     car_adv;
    logic     out_load;
  } dp_cmd_t;

endpackage

// ===== design/fm_tone_oscillator_core.sv =====
// FM tone oscillator core. Each item on the input channel is one stereo frame of two
// signed Q1.15 samples; for each frame the modulator phase advances by its increment,
// the carrier phase advances by carrier_increment scaled by 1 - strength*(0.5 - 0.5*
// sin(modulator)), and the table sine of the new carrier phase times volume (Q16) is
// added to both samples with saturation to 16 bits. One result item per input item,
// in order. Between accepting an item and loading its result into the output
// register, the controller runs in sequence two registered reads of the quarter-wave
// sine table, three passes through the one shared multiplier and the carrier phase
// update; the load waits while the output register holds an untaken result. A new
// item is accepted once the previous one has reached the output register, even
// while that result waits on out_ready. Configuration (cfg_we/cfg_index/cfg_data)
// is to be written by the user only while idle; the block does not enforce it.
// Index 0 carrier increment, 1 modulator increment, 2 strength, 3 volume.
// Depends on fto_pkg, fto_ctrl, fto_datapath and fto_sine_rom.
module fm_tone_oscillator_core
  import fto_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_WIDTH      = PHASE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  // configuration registers, kept at their full register widths
  logic [CFG_DATA_W-1:0] carrier_inc;
  logic [CFG_DATA_W-1:0] modulator_inc;
  logic [GAIN_W-1:0]     strength;
  logic [GAIN_W-1:0]     volume;
  logic [GAIN_W-1:0]     strength_eff;
  dp_cmd_t               ctrl_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_inc   <= CARRIER_INC_RST;
      modulator_inc <= MODULATOR_INC_RST;
      strength      <= STRENGTH_RST;
      volume        <= VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CARRIER_INC:   carrier_inc   <= cfg_data;
        CFG_MODULATOR_INC: modulator_inc <= cfg_data;
        CFG_STRENGTH:      strength      <= cfg_data[GAIN_W-1:0];
        CFG_VOLUME:        volume        <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // strength above one acts as one; volume is used as written
  assign strength_eff = (strength > ONE_Q16) ? ONE_Q16 : strength;

  fto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (ctrl_cmd)
  );

  // increments are cut or zero-extended to the phase width
  fto_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_WIDTH     (PHASE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctrl_cmd),
    .in_data      (in_data),
    .carrier_inc  (PHASE_WIDTH'(carrier_inc)),
    .modulator_inc(PHASE_WIDTH'(modulator_inc)),
    .strength     (strength_eff),
    .volume       (volume),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  // one item in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // the output register is only loaded when its slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken item");

  // a result shows up only after the sequencer loaded one
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl_cmd.out_load))
    else $error("out_valid rose without a load");
`endif

endmodule

// ===== design/fto_ctrl.sv =====
// fto_ctrl: sequencer for the FM tone oscillator, one item at a time.
// Depends on fto_pkg (dp_cmd_t, mul_sel_t).
module fto_ctrl
  import fto_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_MOD_RD    = 8'b0000_0010,
    ST_DEPTH_MUL = 8'b0000_0100,
    ST_STEP_MUL  = 8'b0000_1000,
    ST_CAR_ADV   = 8'b0001_0000,
    ST_CAR_RD    = 8'b0010_0000,
    ST_TONE_MUL  = 8'b0100_0000,
    ST_EMIT      = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.mul_sel     = MUL_DEPTH;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.mod_adv = 1'b1;
          state_next  = ST_MOD_RD;
        end
      end
      ST_MOD_RD: begin
        cmd.rom_rd = 1'b1;
        state_next = ST_DEPTH_MUL;
      end
      ST_DEPTH_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEPTH;
        state_next  = ST_STEP_MUL;
      end
      ST_STEP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STEP;
        state_next  = ST_CAR_ADV;
      end
      ST_CAR_ADV: begin
        cmd.car_adv = 1'b1;
        state_next  = ST_CAR_RD;
      end
      ST_CAR_RD: begin
        cmd.rom_rd      = 1'b1;
        cmd.rom_sel_car = 1'b1;
        state_next      = ST_TONE_MUL;
      end
      ST_TONE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TONE;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/fto_sine_rom.sv =====
// fto_sine_rom: phase to signed Q15 sine through a quarter-wave table.
// Depends on fto_pkg (SINE_W). Table contents are built at elaboration.
module fto_sine_rom
  import fto_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_WIDTH      = PHASE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [PHASE_WIDTH-1:0]   phase,
  output logic signed [SINE_W-1:0] sine
);

  localparam int QTR_LEN = SINE_TABLE_DEPTH / 4;
  localparam int IW      = $clog2(SINE_TABLE_DEPTH);
  localparam int AW      = $clog2(QTR_LEN + 1);
  localparam int SW      = PHASE_WIDTH + IW;

  localparam logic [IW-1:0] Q1 = IW'(QTR_LEN);
  localparam logic [IW-1:0] Q2 = IW'(2 * QTR_LEN);
  localparam logic [IW-1:0] Q3 = IW'(3 * QTR_LEN);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef logic [15:0] rom_t [QTR_LEN+1];

  // Taylor series in Q30 through x^11, rounded to Q15
  function automatic rom_t build_rom();
    rom_t               tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    for (int k = 0; k <= QTR_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / QTR_LEN;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (int n = 0; n < 5; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n & 1) == 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      v = (64'(acc) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tbl[k] = v[15:0];
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SW-1:0]         scaled;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         base;
  logic [IW-1:0]         rem;
  logic [1:0]            quad;
  logic [AW-1:0]         addr;
  logic [15:0]           rom_q;
  logic                  neg_q;
  logic signed [SINE_W-1:0] mag;

  // table index = floor(phase * depth / 2^PHASE_WIDTH)
  assign scaled = SW'(phase) * SW'(SINE_TABLE_DEPTH);
  assign idx    = scaled[SW-1:PHASE_WIDTH];

  always_comb begin
    if (idx >= Q3) begin
      quad = 2'd3;
      base = Q3;
    end else if (idx >= Q2) begin
      quad = 2'd2;
      base = Q2;
    end else if (idx >= Q1) begin
      quad = 2'd1;
      base = Q1;
    end else begin
      quad = 2'd0;
      base = '0;
    end
    rem  = idx - base;
    // odd quadrants run the table backwards
    addr = quad[0] ? (AW'(QTR_LEN) - AW'(rem)) : AW'(rem);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rom_q <= ROM[addr];
      neg_q <= quad[1];
    end
  end

  assign mag  = $signed({1'b0, rom_q});
  assign sine = neg_q ? -mag : mag;

endmodule

// ===== design/fto_datapath.sv =====
// fto_datapath: phase accumulators, sine unit, shared multiplier, output register.
// Depends on fto_pkg and fto_sine_rom; driven by fto_ctrl commands.
module fto_datapath
  import fto_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_WIDTH      = PHASE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  input  in_item_t               in_data,
  input  logic [PHASE_WIDTH-1:0] carrier_inc,
  input  logic [PHASE_WIDTH-1:0] modulator_inc,
  input  logic [GAIN_W-1:0]      strength,
  input  logic [GAIN_W-1:0]      volume,
  output out_item_t              out_data
);

  localparam int MAW = ((PHASE_WIDTH > GAIN_W) ? PHASE_WIDTH : GAIN_W) + 1;
  localparam int MBW = GAIN_W + 1;
  localparam int PRW = MAW + MBW;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [PHASE_WIDTH-1:0]   mod_phase;
  logic [PHASE_WIDTH-1:0]   car_phase;
  logic [PHASE_WIDTH-1:0]   rom_phase;
  logic [PHASE_WIDTH-1:0]   step;
  in_item_t                 in_q;
  logic signed [SINE_W-1:0] sine;
  logic signed [MBW-1:0]    depth;
  logic signed [MBW-1:0]    factor;
  logic signed [MAW-1:0]    mul_a;
  logic signed [MBW-1:0]    mul_b;
  logic signed [PRW-1:0]    prod;
  logic signed [17:0]       tone;
  logic signed [18:0]       sum_l;
  logic signed [18:0]       sum_r;

  assign rom_phase = cmd.rom_sel_car ? car_phase : mod_phase;

  fto_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_WIDTH     (PHASE_WIDTH)
  ) u_sine (
    .clk  (clk),
    .rd_en(cmd.rom_rd),
    .phase(rom_phase),
    .sine (sine)
  );

  // depth = 32768 - sin(mod), factor = 1 - (s * depth) >> 16
  assign depth  = 18'sd32768 - MBW'(sine);
  assign factor = 18'sd65536 - $signed({1'b0, prod[32:16]});
  assign step   = prod[PHASE_WIDTH+15:16];
  assign tone   = prod[33:16];

  always_comb begin
    case (cmd.mul_sel)
      MUL_DEPTH: begin
        mul_a = MAW'($signed({1'b0, strength}));
        mul_b = depth;
      end
      MUL_STEP: begin
        mul_a = MAW'($signed({1'b0, carrier_inc}));
        mul_b = factor;
      end
      MUL_TONE: begin
        mul_a = MAW'(sine);
        mul_b = $signed({1'b0, volume});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_l = 19'(in_q.left_in) + 19'(tone);
  assign sum_r = 19'(in_q.right_in) + 19'(tone);

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_phase <= '0;
      car_phase <= '0;
    end else begin
      if (cmd.mod_adv) begin
        mod_phase <= mod_phase + modulator_inc;
      end
      if (cmd.car_adv) begin
        car_phase <= car_phase + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.mul_en) begin
      prod <= PRW'(mul_a) * PRW'(mul_b);
    end
    if (cmd.out_load) begin
      out_data.left_out  <= sat16(sum_l);
      out_data.right_out <= sat16(sum_r);
    end
  end

endmodule
